// File: hdl/meg_pkg.sv
// shared widths, constants and types of the mesh edge geometry block
package meg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 28;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int ABS_W     = COORD_W;
   localparam int LEN_W     = 29;
   localparam int DIST_W    = 30;
   localparam int GHOST_W   = 30;
   localparam int CD_W      = GHOST_W + 1;
   localparam int NORM_W    = FRAC_BITS + 2;

   localparam int SQ_IN_W   = 60;
   localparam int SQ_ROOT_W = 30;
   localparam int SQ_TMP_W  = SQ_IN_W + 2;

   localparam int DIV_N_W   = ABS_W + FRAC_BITS + 1;
   localparam int DIV_D_W   = LEN_W;
   localparam int DIV_Q_W   = FRAC_BITS + 1;
   localparam int DIV_TMP_W = DIV_N_W + 1;

   localparam int REQ_DATA_W = 8 * COORD_W;
   localparam int RSP_BITS   = 2 * NORM_W + 2 * COORD_W + LEN_W + DIST_W + 2 * GHOST_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                      vld;
      logic                      degen;
      logic                      flip;
      logic                      neg_x;
      logic                      neg_y;
      logic [ABS_W-1:0]          adx;
      logic [ABS_W-1:0]          ady;
      logic signed [COORD_W-1:0] mid_x;
      logic signed [COORD_W-1:0] mid_y;
      logic signed [GHOST_W-1:0] ghost_x;
      logic signed [GHOST_W-1:0] ghost_y;
   } info_type;

   typedef struct packed {
      info_type                  info;
      logic [LEN_W-1:0]          len;
      logic [DIST_W-1:0]         cdist;
   } post_type;

endpackage

// File: hdl/meg_sqrt.sv
// pipelined integer square root, one root bit per stage
module meg_sqrt import meg_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [SQ_IN_W-1:0]   sq_in,
   output logic [SQ_ROOT_W-1:0] root
);

   logic [SQ_IN_W-1:0]   rem_ff  [0:SQ_ROOT_W-1];
   logic [SQ_ROOT_W-1:0] root_ff [0:SQ_ROOT_W-1];

   for (genvar j = 0; j < SQ_ROOT_W; j++) begin : g_stg
      localparam int B = SQ_ROOT_W - 1 - j;
      logic [SQ_IN_W-1:0]   cur_rem;
      logic [SQ_ROOT_W-1:0] cur_root;
      logic [SQ_TMP_W-1:0]  trial;
      logic                 take;
      logic [SQ_IN_W-1:0]   rem_in;
      logic [SQ_ROOT_W-1:0] root_in;

      if (j == 0) begin : g_first
         assign cur_rem  = sq_in;
         assign cur_root = '0;
      end else begin : g_next
         assign cur_rem  = rem_ff[j-1];
         assign cur_root = root_ff[j-1];
      end

      // (r + 2^b)^2 - r^2 with the low bits of r still clear
      assign trial   = (SQ_TMP_W'(cur_root) << (B + 1)) + (SQ_TMP_W'(1) << (2 * B));
      assign take    = SQ_TMP_W'(cur_rem) >= trial;
      assign rem_in  = take ? (cur_rem - trial[SQ_IN_W-1:0]) : cur_rem;
      assign root_in = take ? (cur_root | (SQ_ROOT_W'(1) << B)) : cur_root;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign root = root_ff[SQ_ROOT_W-1];

endmodule

// File: hdl/meg_div.sv
// pipelined restoring divider, one quotient bit per stage
module meg_div import meg_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [DIV_N_W-1:0] num,
   input  logic [DIV_D_W-1:0] den,
   output logic [DIV_Q_W-1:0] quo
);

   logic [DIV_N_W-1:0] rem_ff [0:DIV_Q_W-1];
   logic [DIV_D_W-1:0] den_ff [0:DIV_Q_W-1];
   logic [DIV_Q_W-1:0] quo_ff [0:DIV_Q_W-1];

   for (genvar j = 0; j < DIV_Q_W; j++) begin : g_stg
      localparam int Q = DIV_Q_W - 1 - j;
      logic [DIV_N_W-1:0]   cur_rem;
      logic [DIV_D_W-1:0]   cur_den;
      logic [DIV_Q_W-1:0]   cur_quo;
      logic [DIV_TMP_W-1:0] shifted;
      logic                 take;

      if (j == 0) begin : g_first
         assign cur_rem = num;
         assign cur_den = den;
         assign cur_quo = '0;
      end else begin : g_next
         assign cur_rem = rem_ff[j-1];
         assign cur_den = den_ff[j-1];
         assign cur_quo = quo_ff[j-1];
      end

      assign shifted = DIV_TMP_W'(cur_den) << Q;
      assign take    = DIV_TMP_W'(cur_rem) >= shifted;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? (cur_rem - shifted[DIV_N_W-1:0]) : cur_rem;
            den_ff[j] <= cur_den;
            quo_ff[j] <= take ? (cur_quo | (DIV_Q_W'(1) << Q)) : cur_quo;
         end
      end
   end

   assign quo = quo_ff[DIV_Q_W-1];

endmodule

// File: hdl/mesh_edge_geometry.sv
// top level of the mesh edge geometry pipeline
// One request per mesh edge gives one result: edge length, unit normal pointing
// away from the left cell, midpoint, right or ghost centroid and centroid distance.
// The block is a single pipeline that takes a new request every cycle unless stalled;
// its stages are the input stages, the bit-per-stage square root (30 stages), the
// operand stage, the bit-per-stage normal divider (17 stages) and the output register.
// The whole pipeline holds while a result sits in the output register and rsp_tready is low.
module mesh_edge_geometry import meg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_x, start_y, end_x, end_y, left_x, left_y, right_x, right_y (28 bits each)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // is_boundary
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // normal_x, normal_y, mid_x, mid_y, edge_length, center_distance, ghost_x, ghost_y,
   // zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic                  rsp_tuser
);

   localparam int SQ_LAT  = SQ_ROOT_W;
   localparam int DIV_LAT = DIV_Q_W;

   // global advance: output register empty or being taken
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // unpack the request
   logic signed [COORD_W-1:0] sx, sy, ex, ey, lx, ly, rx, ry;
   assign sx = req_tdata[0*COORD_W +: COORD_W];
   assign sy = req_tdata[1*COORD_W +: COORD_W];
   assign ex = req_tdata[2*COORD_W +: COORD_W];
   assign ey = req_tdata[3*COORD_W +: COORD_W];
   assign lx = req_tdata[4*COORD_W +: COORD_W];
   assign ly = req_tdata[5*COORD_W +: COORD_W];
   assign rx = req_tdata[6*COORD_W +: COORD_W];
   assign ry = req_tdata[7*COORD_W +: COORD_W];

   // stage 1: differences, ghost centroid, midpoint
   logic signed [DIFF_W-1:0]  dx, dy, lsx, lsy, sum_x, sum_y, adx_w, ady_w;
   logic signed [GHOST_W-1:0] gx, gy;
   logic signed [CD_W-1:0]    cdx, cdy, acdx_w, acdy_w;
   logic signed [DIFF_W-1:0]  mid_x_w, mid_y_w;
   info_type                  s1_info_in;

   always_comb begin
      dx    = DIFF_W'(ex) - DIFF_W'(sx);
      dy    = DIFF_W'(ey) - DIFF_W'(sy);
      lsx   = DIFF_W'(lx) - DIFF_W'(sx);
      lsy   = DIFF_W'(ly) - DIFF_W'(sy);
      sum_x = DIFF_W'(sx) + DIFF_W'(ex);
      sum_y = DIFF_W'(sy) + DIFF_W'(ey);
      adx_w = dx[DIFF_W-1] ? -dx : dx;
      ady_w = dy[DIFF_W-1] ? -dy : dy;
      // ghost is start + end - left on boundary edges
      gx    = req_tuser ? (GHOST_W'(sum_x) - GHOST_W'(lx)) : GHOST_W'(rx);
      gy    = req_tuser ? (GHOST_W'(sum_y) - GHOST_W'(ly)) : GHOST_W'(ry);
      cdx   = CD_W'(lx) - CD_W'(gx);
      cdy   = CD_W'(ly) - CD_W'(gy);
      acdx_w = cdx[CD_W-1] ? -cdx : cdx;
      acdy_w = cdy[CD_W-1] ? -cdy : cdy;
      mid_x_w = sum_x >>> 1;
      mid_y_w = sum_y >>> 1;

      s1_info_in.vld     = req_tvalid;
      s1_info_in.degen   = (dx == '0) && (dy == '0);
      s1_info_in.flip    = 1'b0;
      s1_info_in.neg_x   = dy[DIFF_W-1];
      s1_info_in.neg_y   = !dx[DIFF_W-1] && (dx != '0);
      s1_info_in.adx     = adx_w[ABS_W-1:0];
      s1_info_in.ady     = ady_w[ABS_W-1:0];
      s1_info_in.mid_x   = mid_x_w[COORD_W-1:0];
      s1_info_in.mid_y   = mid_y_w[COORD_W-1:0];
      s1_info_in.ghost_x = gx;
      s1_info_in.ghost_y = gy;
   end

   info_type                 s1_info_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_lsx_ff, s1_lsy_ff;
   logic [DIST_W-1:0]        s1_acdx_ff, s1_acdy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_info_ff.vld <= 1'b0;
      end else if (en) begin
         s1_info_ff.vld <= s1_info_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_info_ff.degen   <= s1_info_in.degen;
         s1_info_ff.flip    <= s1_info_in.flip;
         s1_info_ff.neg_x   <= s1_info_in.neg_x;
         s1_info_ff.neg_y   <= s1_info_in.neg_y;
         s1_info_ff.adx     <= s1_info_in.adx;
         s1_info_ff.ady     <= s1_info_in.ady;
         s1_info_ff.mid_x   <= s1_info_in.mid_x;
         s1_info_ff.mid_y   <= s1_info_in.mid_y;
         s1_info_ff.ghost_x <= s1_info_in.ghost_x;
         s1_info_ff.ghost_y <= s1_info_in.ghost_y;
         s1_dx_ff   <= dx;
         s1_dy_ff   <= dy;
         s1_lsx_ff  <= lsx;
         s1_lsy_ff  <= lsy;
         s1_acdx_ff <= acdx_w[DIST_W-1:0];
         s1_acdy_ff <= acdy_w[DIST_W-1:0];
      end
   end

   // stage 2: squares and orientation cross products
   info_type                     s2_info_ff;
   logic [2*ABS_W-1:0]           s2_plx_ff, s2_ply_ff;
   logic [2*DIST_W-1:0]          s2_pcx_ff, s2_pcy_ff;
   logic signed [2*DIFF_W-1:0]   s2_ps1_ff, s2_ps2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_info_ff.vld <= 1'b0;
      end else if (en) begin
         s2_info_ff.vld <= s1_info_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_info_ff.degen   <= s1_info_ff.degen;
         s2_info_ff.flip    <= s1_info_ff.flip;
         s2_info_ff.neg_x   <= s1_info_ff.neg_x;
         s2_info_ff.neg_y   <= s1_info_ff.neg_y;
         s2_info_ff.adx     <= s1_info_ff.adx;
         s2_info_ff.ady     <= s1_info_ff.ady;
         s2_info_ff.mid_x   <= s1_info_ff.mid_x;
         s2_info_ff.mid_y   <= s1_info_ff.mid_y;
         s2_info_ff.ghost_x <= s1_info_ff.ghost_x;
         s2_info_ff.ghost_y <= s1_info_ff.ghost_y;
         s2_plx_ff <= s1_info_ff.adx * s1_info_ff.adx;
         s2_ply_ff <= s1_info_ff.ady * s1_info_ff.ady;
         s2_pcx_ff <= s1_acdx_ff * s1_acdx_ff;
         s2_pcy_ff <= s1_acdy_ff * s1_acdy_ff;
         s2_ps1_ff <= s1_lsx_ff * s1_dy_ff;
         s2_ps2_ff <= s1_lsy_ff * s1_dx_ff;
      end
   end

   // stage 3: sums of squares and side test
   logic signed [2*DIFF_W:0] side_w;
   assign side_w = (2*DIFF_W+1)'(s2_ps1_ff) - (2*DIFF_W+1)'(s2_ps2_ff);

   info_type           s3_info_ff;
   logic [SQ_IN_W-1:0] s3_len_sq_ff, s3_dist_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_info_ff.vld <= 1'b0;
      end else if (en) begin
         s3_info_ff.vld <= s2_info_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_info_ff.degen   <= s2_info_ff.degen;
         // left centroid strictly on the positive side turns the normal
         s3_info_ff.flip    <= !side_w[2*DIFF_W] && (side_w != '0);
         s3_info_ff.neg_x   <= s2_info_ff.neg_x;
         s3_info_ff.neg_y   <= s2_info_ff.neg_y;
         s3_info_ff.adx     <= s2_info_ff.adx;
         s3_info_ff.ady     <= s2_info_ff.ady;
         s3_info_ff.mid_x   <= s2_info_ff.mid_x;
         s3_info_ff.mid_y   <= s2_info_ff.mid_y;
         s3_info_ff.ghost_x <= s2_info_ff.ghost_x;
         s3_info_ff.ghost_y <= s2_info_ff.ghost_y;
         s3_len_sq_ff  <= SQ_IN_W'(s2_plx_ff) + SQ_IN_W'(s2_ply_ff);
         s3_dist_sq_ff <= SQ_IN_W'(s2_pcx_ff) + SQ_IN_W'(s2_pcy_ff);
      end
   end

   // square roots, side data rides a matching delay line
   logic [SQ_ROOT_W-1:0] len_root, dist_root;

   meg_sqrt u_len_sqrt (
      .clock (clock),
      .en    (en),
      .sq_in (s3_len_sq_ff),
      .root  (len_root)
   );

   meg_sqrt u_dist_sqrt (
      .clock (clock),
      .en    (en),
      .sq_in (s3_dist_sq_ff),
      .root  (dist_root)
   );

   info_type sq_dly_ff [0:SQ_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_LAT; k++) begin
            sq_dly_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         sq_dly_ff[0] <= s3_info_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            sq_dly_ff[k] <= sq_dly_ff[k-1];
         end
      end
   end

   // stage 4: divider operands, |d| * 2^frac + len/2
   post_type           s4_post_ff;
   logic [DIV_N_W-1:0] s4_num_x_ff, s4_num_y_ff;
   logic [LEN_W-1:0]   len_w;
   assign len_w = len_root[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_post_ff.info.vld <= 1'b0;
      end else if (en) begin
         s4_post_ff.info.vld <= sq_dly_ff[SQ_LAT-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_post_ff.info[$bits(info_type)-2:0] <= sq_dly_ff[SQ_LAT-1][$bits(info_type)-2:0];
         s4_post_ff.len   <= sq_dly_ff[SQ_LAT-1].degen ? '0 : len_w;
         s4_post_ff.cdist <= dist_root[DIST_W-1:0];
         s4_num_x_ff <= (DIV_N_W'(sq_dly_ff[SQ_LAT-1].ady) << FRAC_BITS)
                      + DIV_N_W'(len_w >> 1);
         s4_num_y_ff <= (DIV_N_W'(sq_dly_ff[SQ_LAT-1].adx) << FRAC_BITS)
                      + DIV_N_W'(len_w >> 1);
      end
   end

   // normal magnitudes
   logic [DIV_Q_W-1:0] quo_x, quo_y;

   meg_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (s4_num_x_ff),
      .den   (s4_post_ff.len),
      .quo   (quo_x)
   );

   meg_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (s4_num_y_ff),
      .den   (s4_post_ff.len),
      .quo   (quo_y)
   );

   post_type div_dly_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            div_dly_ff[k].info.vld <= 1'b0;
         end
      end else if (en) begin
         div_dly_ff[0] <= s4_post_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            div_dly_ff[k] <= div_dly_ff[k-1];
         end
      end
   end

   // output stage: sign, orientation flip, zero-length edge
   post_type                 fin;
   logic signed [NORM_W-1:0] mag_x, mag_y, nx_w, ny_w;
   logic [RSP_DATA_W-1:0]    rsp_data_in;

   always_comb begin
      fin   = div_dly_ff[DIV_LAT-1];
      mag_x = NORM_W'(quo_x);
      mag_y = NORM_W'(quo_y);
      nx_w  = (fin.info.neg_x ^ fin.info.flip) ? -mag_x : mag_x;
      ny_w  = (fin.info.neg_y ^ fin.info.flip) ? -mag_y : mag_y;
      if (fin.info.degen) begin
         nx_w = '0;
         ny_w = '0;
      end
      rsp_data_in = RSP_DATA_W'({fin.info.ghost_y, fin.info.ghost_x, fin.cdist, fin.len,
                                 fin.info.mid_y, fin.info.mid_x, ny_w, nx_w});
   end

   logic                  rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= fin.info.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_degen_ff <= fin.info.degen;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_degen_ff;

endmodule

// File: bench/tb_mesh_edge_geometry.sv
// testbench for the mesh edge geometry pipeline
`timescale 1ns / 1ps

module tb_mesh_edge_geometry import meg_pkg::*; ();

   // one accepted request
   typedef struct {
      logic signed [COORD_W-1:0] sx, sy, ex, ey, lx, ly, rx, ry;
      logic                      bnd;
   } edge_req_type;

   // one expected or observed result
   typedef struct packed {
      logic [NORM_W-1:0]  nx, ny;
      logic [COORD_W-1:0] mx, my;
      logic [LEN_W-1:0]   len;
      logic [DIST_W-1:0]  cdist;
      logic [GHOST_W-1:0] gx, gy;
      logic               degen;
   } edge_geom_type;

   // exact floor of integer square root
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // rounded signed component of d / len in Q1.FRAC_BITS
   function automatic longint unit_comp(longint d, longint unsigned len);
      longint unsigned mag, ad;
      ad = (d < 0) ? -d : d;
      mag = ((ad << FRAC_BITS) + len / 2) / len;
      return (d < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint half_floor(longint s);
      return s >>> 1;
   endfunction

   function automatic edge_geom_type edge_geometry(edge_req_type r);
      edge_geom_type g;
      longint sx, sy, ex, ey, lx, ly, dx, dy, nx, ny, side, gx, gy, cdx, cdy, mx, my;
      longint unsigned len, cdist;
      sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey; lx = r.lx; ly = r.ly;
      dx = ex - sx;
      dy = ey - sy;
      len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
      nx = 0;
      ny = 0;
      g.degen = (dx == 0 && dy == 0);
      if (!g.degen) begin
         side = (lx - sx) * dy - (ly - sy) * dx;
         nx = unit_comp(dy, len);
         ny = unit_comp(-dx, len);
         if (side > 0) begin
            nx = -nx;
            ny = -ny;
         end
      end
      gx = r.bnd ? (sx + ex - lx) : longint'(r.rx);
      gy = r.bnd ? (sy + ey - ly) : longint'(r.ry);
      cdx = lx - gx;
      cdy = ly - gy;
      cdist = int_sqrt(cdx * cdx + cdy * cdy);
      mx = half_floor(sx + ex);
      my = half_floor(sy + ey);
      g.nx = nx[NORM_W-1:0];
      g.ny = ny[NORM_W-1:0];
      g.mx = mx[COORD_W-1:0];
      g.my = my[COORD_W-1:0];
      g.len = len[LEN_W-1:0];
      g.cdist = cdist[DIST_W-1:0];
      g.gx = gx[GHOST_W-1:0];
      g.gy = gy[GHOST_W-1:0];
      return g;
   endfunction

   // holds expected geometry in order and compares results against it
   class geom_scoreboard;
      edge_geom_type pending[$];
      int            errors;
      int            checked;

      function void note_request(edge_req_type r);
         pending.push_back(edge_geometry(r));
      endfunction

      function void check_result(edge_geom_type got);
         edge_geom_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result with nothing pending");
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch #%0d exp n=%h,%h m=%h,%h l=%h d=%h g=%h,%h dg=%b",
                        checked, exp.nx, exp.ny, exp.mx, exp.my, exp.len, exp.cdist,
                        exp.gx, exp.gy, exp.degen,
                        "\n              got n=%h,%h m=%h,%h l=%h d=%h g=%h,%h dg=%b",
                        got.nx, got.ny, got.mx, got.my, got.len, got.cdist,
                        got.gx, got.gy, got.degen);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // start_x, start_y, end_x, end_y, left_x, left_y, right_x, right_y
   logic [REQ_DATA_W-1:0] req_tdata;
   // is_boundary
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // normals, midpoint, length, distance, ghost, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // degenerate
   logic                  rsp_tuser;

   geom_scoreboard sb;
   bit             no_idle;     // stretch with no idling on either side
   int             n_bnd, n_degen, n_req;

   localparam int LATENCY = 52;
   localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

   mesh_edge_geometry i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit: far above the slowest correct run
   initial begin
      #20ms;
      $display("tb_mesh_edge_geometry: FAIL");
      $finish;
   end

   // result side: random stall, sample at rising edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= no_idle || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      edge_geom_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {got.gy, got.gx, got.cdist, got.len, got.my, got.mx, got.ny, got.nx} =
            rsp_tdata[RSP_BITS-1:0];
         got.degen = rsp_tuser;
         sb.check_result(got);
      end
   end

   // one request: hold valid until accepted, idle gaps before it at random
   task automatic send_edge(edge_req_type r);
      while (!no_idle && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.ry, r.rx, r.ly, r.lx, r.ey, r.ex, r.sy, r.sx};
      req_tuser  <= r.bnd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      n_req++;
      n_bnd += r.bnd;
      n_degen += (r.sx == r.ex && r.sy == r.ey);
      @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
      logic signed [COORD_W-1:0] v;
      case (mode)
         0: v = COORD_W'($urandom);
         1: v = COORD_W'($signed($urandom_range(4095)) - 2048);
         2: v = $urandom_range(1) ? CMAX - COORD_W'($urandom_range(3))
                                  : CMIN + COORD_W'($urandom_range(3));
         default: v = COORD_W'($signed(COORD_W'($urandom_range(1 << 22))) - (1 << 21));
      endcase
      return v;
   endfunction

   function automatic edge_req_type rand_edge();
      edge_req_type r;
      int m;
      m = $urandom_range(3);
      r.sx = rand_coord(m); r.sy = rand_coord(m);
      r.ex = rand_coord(m); r.ey = rand_coord(m);
      r.lx = rand_coord(m); r.ly = rand_coord(m);
      r.rx = rand_coord(m); r.ry = rand_coord(m);
      r.bnd = 1'($urandom_range(1));
      case ($urandom_range(15))
         0: begin r.ex = r.sx; r.ey = r.sy; end        // zero-length edge
         1: begin r.ex = r.sx; end                      // vertical edge
         2: begin r.ey = r.sy; end                      // horizontal edge
         3: begin r.lx = r.sx; r.ly = r.sy; end        // left centroid on the line
         default: ;
      endcase
      return r;
   endfunction

   task automatic wait_drained();
      do @(negedge clock); while (sb.pending.size() != 0);
   endtask

   function automatic edge_req_type mk(logic signed [COORD_W-1:0] sx, sy, ex, ey, lx, ly,
                                       rx, ry, logic bnd);
      edge_req_type r;
      r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
      r.lx = lx; r.ly = ly; r.rx = rx; r.ry = ry; r.bnd = bnd;
      return r;
   endfunction

   initial begin
      sb = new();
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: degenerate, axis edges, flips, extremes, centroid on the line
      send_edge(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_edge(mk(100, 200, 100, 200, 5, 7, 9, 11, 1));
      send_edge(mk(0, 0, 65536, 0, 0, 65536, 0, -65536, 0));
      send_edge(mk(0, 0, 65536, 0, 0, -65536, 0, 65536, 1));
      send_edge(mk(0, 0, 0, 65536, 65536, 0, -65536, 0, 0));
      send_edge(mk(0, 0, 0, 65536, -65536, 0, 65536, 0, 1));
      send_edge(mk(0, 0, 3, 4, 1, 1, 2, 2, 0));
      send_edge(mk(0, 0, 65536, 65536, 131072, 131072, 0, 0, 1));
      send_edge(mk(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, 0));
      send_edge(mk(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, 1));
      send_edge(mk(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, 1));
      send_edge(mk(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1));
      send_edge(mk(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, 0));
      send_edge(mk(-1, -1, 0, 0, -3, 5, -1, -1, 0));
      send_edge(mk(-3, 1, 0, 2, 4, -4, 1, 1, 1));
      send_edge(mk(1, 1, 2, 1, 7, 7, 7, 7, 0));
      send_edge(mk(0, 0, CMAX, 0, 0, 1, 0, 0, 1));
      send_edge(mk(0, 0, 0, CMIN, 1, 0, 0, 0, 1));

      // hold off until the pipeline has drained
      req_tvalid <= 1'b0;
      wait_drained();

      for (int i = 0; i < 1500; i++) begin
         no_idle = (i >= 600 && i < 800);
         if (i == 1000) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         send_edge(rand_edge());
      end
      req_tvalid <= 1'b0;

      fork
         begin
            wait_drained();
            repeat (LATENCY + 10) @(posedge clock);
         end
         begin
            repeat (200000) @(posedge clock);
         end
      join_any

      $display("covered %0d edges: %0d boundary, %0d zero-length, %0d results checked",
               n_req, n_bnd, n_degen, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_mesh_edge_geometry: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
         $display("tb_mesh_edge_geometry: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/meg_pkg.sv
hdl/meg_sqrt.sv
hdl/meg_div.sv
hdl/mesh_edge_geometry.sv
bench/tb_mesh_edge_geometry.sv
